>>> rtl/hfir_pkg.sv
// shared types, constants and control bundles for the hilbert fir i/q generator
`timescale 1ns / 1ps

package hfir_pkg;

    // sample and accumulator widths
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;

    // 2/pi in q16, and the output scaling shift
    localparam logic [16:0] TWO_OVER_PI_Q16 = 17'd41722;
    localparam int          Q_SHIFT         = 16;

    // shared divider: quotient bits resolved per cycle
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STEPS     = ACC_W / DIV_STEP_BITS;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ACC_W-1:0]           acc_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch new sample, clear accumulator, first tap
        logic rd_centre;   // read the centre (i) sample instead of the tap
        logic load_i;      // keep the centre sample
        logic load_prod;   // multiply the tap sample by 2/pi
        logic div_start;   // start dividing the product by the tap offset
        logic acc_add;     // add the signed quotient
        logic tap_next;    // step to the next odd offset
        logic load_out;    // move i/q into the output register
        logic write_back;  // shift the new sample into the history
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic last_tap;
    } status_t;

endpackage

>>> rtl/hfir_sample_if.sv
// input channel carrying one audio sample per transfer
`timescale 1ns / 1ps

interface hfir_sample_if;
    logic             valid;
    logic             ready;
    hfir_pkg::sample_t audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink   (input valid, input audio_sample, output ready);
endinterface

>>> rtl/hfir_iq_if.sv
// output channel carrying one i/q pair per transfer
`timescale 1ns / 1ps

interface hfir_iq_if;
    logic             valid;
    logic             ready;
    hfir_pkg::sample_t i_out;
    hfir_pkg::sample_t q_out;

    modport source (output valid, output i_out, output q_out, input ready);
    modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

>>> rtl/hilbert_fir_iq_generator_top.sv
// top level of the hilbert fir i/q generator
//
//   channel  | dir | payload                 | transfer when
//   ---------+-----+-------------------------+---------------------
//   samples  | in  | audio_sample (s16)      | valid && ready
//   iq       | out | i_out (s16), q_out (s16)| valid && ready
//
// one sample is worked at a time; its pace is set by the shared divider,
// which resolves 4 quotient bits a cycle. each odd tap in turn is read from
// the history, multiplied by 2/pi, started in the divider, divided and then
// added into the accumulator before the next tap is addressed.
// the finished pair sits in an output register, so a new sample is taken
// while the previous pair is still waiting; the block only holds in its last
// step when that register is still full. reset is asynchronous, active low;
// the history reads as zero until filled, tracked by a fill count.
`timescale 1ns / 1ps

module hilbert_fir_iq_generator_top #(
    parameter int HALF_WINDOW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    hfir_sample_if.sink   samples,
    hfir_iq_if.source     iq
);

    hfir_pkg::cmd_t    cmd;
    hfir_pkg::status_t status;
    logic              in_ready;
    logic              out_valid;
    hfir_pkg::sample_t i_out;
    hfir_pkg::sample_t q_out;

    // sequencing
    hfir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (iq.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and storage
    hfir_datapath #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .audio_sample (samples.audio_sample),
        .i_out        (i_out),
        .q_out        (q_out)
    );

    assign samples.ready = in_ready;
    assign iq.valid      = out_valid;
    assign iq.i_out      = i_out;
    assign iq.q_out      = q_out;

    // a new pair never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!iq.valid || iq.ready))
        else $error("output register overwritten while full");

    // the divider cannot report completion the cycle after it starts
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider finished too early");

    // only one sample is in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second sample taken while one is in work");

endmodule

>>> rtl/hfir_divider.sv
// iterative unsigned divider, a few quotient bits per cycle
`timescale 1ns / 1ps

module hfir_divider #(
    parameter int DIVISOR_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  hfir_pkg::acc_t       dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output hfir_pkg::acc_t       quotient,
    output logic                 done
);

    localparam int STEP_W = (hfir_pkg::DIV_STEPS > 1) ? $clog2(hfir_pkg::DIV_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(hfir_pkg::DIV_STEPS - 1);

    hfir_pkg::acc_t        quo_reg;
    hfir_pkg::acc_t        quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;

    // restoring division: dividend shifts out of the top as quotient bits shift in
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < hfir_pkg::DIV_STEP_BITS; i++)
        begin
            trial    = {rem_next, quo_next[hfir_pkg::ACC_W-1]};
            quo_next = {quo_next[hfir_pkg::ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next    = DIVISOR_W'(trial - {1'b0, divisor});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
        end
    end

    // step sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> rtl/hfir_datapath.sv
// history memory, tap addressing, multiplier, divider and accumulator
`timescale 1ns / 1ps

module hfir_datapath #(
    parameter int HALF_WINDOW = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hfir_pkg::cmd_t    cmd,
    output hfir_pkg::status_t status,
    input  hfir_pkg::sample_t audio_sample,
    output hfir_pkg::sample_t i_out,
    output hfir_pkg::sample_t q_out
);

    localparam int HIST_LEN = 2 * HALF_WINDOW;
    localparam int AW       = $clog2(HIST_LEN);
    localparam int CNT_W    = $clog2(HIST_LEN + 1);
    localparam int DW       = $clog2(HALF_WINDOW + 1);
    localparam int VW       = AW + 2;
    localparam int K_FIRST_I = (HALF_WINDOW % 2 == 1) ? 0 : 1;

    localparam logic [AW:0]      HIST_LEN_C = HIST_LEN[AW:0];
    localparam logic [AW:0]      HALF_C     = HALF_WINDOW[AW:0];
    localparam logic [AW-1:0]    HALF_K     = HALF_WINDOW[AW-1:0];
    localparam logic [AW-1:0]    K_FIRST    = K_FIRST_I[AW-1:0];
    localparam logic [AW-1:0]    WP_LAST    = AW'(HIST_LEN - 1);
    localparam logic [AW:0]      TAP_STRIDE = (AW+1)'(2);
    localparam logic [CNT_W-1:0] HIST_CNT   = HIST_LEN[CNT_W-1:0];
    localparam logic [VW-1:0]    HIST_LEN_V = HIST_LEN[VW-1:0];

    // history memory, oldest sample at wp_reg
    logic [hfir_pkg::SAMPLE_W-1:0] mem [HIST_LEN];

    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [AW-1:0]    k_reg;
    logic [AW:0]      k_plus2;

    hfir_pkg::sample_t              sample_reg;
    logic [hfir_pkg::SAMPLE_W-1:0]  rd_data_reg;
    logic                           rd_valid_reg;
    logic [hfir_pkg::SAMPLE_W-1:0]  centre_reg;
    hfir_pkg::acc_t                 prod_reg;
    logic                           term_neg_reg;
    hfir_pkg::acc_t                 acc_reg;
    hfir_pkg::sample_t              i_out_reg;
    hfir_pkg::sample_t              q_out_reg;

    logic [AW:0]     tap_sum;
    logic [AW:0]     tap_wrap;
    logic [AW:0]     centre_sum;
    logic [AW:0]     centre_wrap;
    logic [AW-1:0]   tap_addr;
    logic [AW-1:0]   centre_addr;
    logic [AW-1:0]   rd_addr;
    logic [VW-1:0]   rd_index;
    logic            rd_valid;

    logic [hfir_pkg::SAMPLE_W-1:0] x_sel;
    logic [hfir_pkg::SAMPLE_W:0]   x_ext;
    logic [hfir_pkg::SAMPLE_W:0]   x_abs;
    logic [33:0]                   product;
    logic                          d_neg;
    logic [AW-1:0]                 d_diff;
    logic [DW-1:0]                 d_abs;
    hfir_pkg::acc_t                quotient;
    logic                          div_done;
    hfir_pkg::acc_t                term;
    hfir_pkg::acc_t                neg_sum;

    // logical index to circular address
    assign tap_sum     = {1'b0, wp_reg} + {1'b0, k_reg};
    assign tap_wrap    = tap_sum - HIST_LEN_C;
    assign tap_addr    = (tap_sum >= HIST_LEN_C) ? tap_wrap[AW-1:0] : tap_sum[AW-1:0];
    assign centre_sum  = {1'b0, wp_reg} + HALF_C;
    assign centre_wrap = centre_sum - HIST_LEN_C;
    assign centre_addr = (centre_sum >= HIST_LEN_C) ? centre_wrap[AW-1:0]
                                                    : centre_sum[AW-1:0];
    assign rd_addr     = cmd.rd_centre ? centre_addr : tap_addr;

    // entries not yet filled since reset read as zero
    assign rd_index = cmd.rd_centre ? VW'(HALF_C) : VW'(k_reg);
    assign rd_valid = (rd_index + VW'(count_reg)) >= HIST_LEN_V;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_back)
        begin
            mem[wp_reg] <= sample_reg;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= rd_valid;
    end

    // tap offset sign and magnitude
    assign d_neg  = k_reg < HALF_K;
    assign d_diff = d_neg ? (HALF_K - k_reg) : (k_reg - HALF_K);
    assign d_abs  = d_diff[DW-1:0];

    // magnitude product 2/pi * |x|
    assign x_sel   = rd_valid_reg ? rd_data_reg : '0;
    assign x_ext   = {x_sel[hfir_pkg::SAMPLE_W-1], x_sel};
    assign x_abs   = x_sel[hfir_pkg::SAMPLE_W-1] ? (17'd0 - x_ext) : x_ext;
    assign product = hfir_pkg::TWO_OVER_PI_Q16 * x_abs;

    hfir_divider #(
        .DIVISOR_W (DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (d_abs),
        .quotient (quotient),
        .done     (div_done)
    );

    // signed term and negated sum
    assign term    = term_neg_reg ? (32'd0 - quotient) : quotient;
    assign neg_sum = 32'd0 - acc_reg;

    assign k_plus2 = {1'b0, k_reg} + TAP_STRIDE;

    // pointer and fill count advance
    always_comb
    begin
        wp_next    = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
        count_next = (count_reg == HIST_CNT) ? count_reg : count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.write_back)
        begin
            wp_reg    <= wp_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= audio_sample;
            acc_reg    <= '0;
            k_reg      <= K_FIRST;
        end
        else
        begin
            if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + term;
            end
            if (cmd.tap_next)
            begin
                k_reg <= k_plus2[AW-1:0];
            end
        end
        if (cmd.load_i)
        begin
            centre_reg <= x_sel;
        end
        if (cmd.load_prod)
        begin
            prod_reg     <= product[hfir_pkg::ACC_W-1:0];
            term_neg_reg <= x_sel[hfir_pkg::SAMPLE_W-1] ^ d_neg;
        end
        if (cmd.load_out)
        begin
            i_out_reg <= centre_reg;
            q_out_reg <= neg_sum[hfir_pkg::Q_SHIFT +: hfir_pkg::SAMPLE_W];
        end
    end

    assign status.div_done = div_done;
    assign status.last_tap = k_plus2 >= HIST_LEN_C;
    assign i_out           = i_out_reg;
    assign q_out           = q_out_reg;

endmodule

>>> rtl/hfir_ctrl.sv
// controller state machine sequencing one sample through the taps
`timescale 1ns / 1ps

module hfir_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  hfir_pkg::status_t status,
    output hfir_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CENTRE,
        ST_LD_CENTRE,
        ST_TAP_ADDR,
        ST_TAP_MUL,
        ST_TAP_START,
        ST_TAP_WAIT,
        ST_TAP_ACC,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RD_CENTRE;
                end
            end
            ST_RD_CENTRE:
            begin
                cmd.rd_centre = 1'b1;
                state_next    = ST_LD_CENTRE;
            end
            ST_LD_CENTRE:
            begin
                cmd.load_i = 1'b1;
                state_next = ST_TAP_MUL;
            end
            ST_TAP_ADDR:
            begin
                state_next = ST_TAP_MUL;
            end
            ST_TAP_MUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = ST_TAP_START;
            end
            ST_TAP_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_TAP_WAIT;
            end
            ST_TAP_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_TAP_ACC;
                end
            end
            ST_TAP_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (status.last_tap)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.tap_next = 1'b1;
                    state_next   = ST_TAP_ADDR;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.write_back = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
